// ===== rtl/assert_macros.svh =====
// assertion helper macros for the pattern unpacker rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/itpu_pkg.sv =====
// shared types and constants of the pattern unpacker
// no dependencies
`timescale 1ns / 1ps

package itpu_pkg;

  // per-channel stores are always indexed by six channel bits
  localparam int StoreDepth  = 64;
  localparam int ChanW       = 6;
  localparam int MaskW       = 8;
  localparam int DefChannels = 64;

  // configuration register indexes
  localparam logic RegPatternRows  = 1'b0;
  localparam logic RegPatternBytes = 1'b1;

  // register reset values
  localparam logic [15:0] PatternRowsRst  = 16'd64;
  localparam logic [15:0] PatternBytesRst = 16'd0;

  // field codes
  localparam logic [7:0] NoteLimit    = 8'd120;
  localparam logic [7:0] InstrMax     = 8'd31;
  localparam logic [7:0] VolLimit     = 8'd64;
  localparam logic [7:0] FxSpeedA     = 8'd1;
  localparam logic [7:0] FxSpeedB     = 8'd20;
  localparam logic [3:0] FxSetVolume  = 4'hC;
  localparam logic [3:0] FxSetSpeed   = 4'hF;
  localparam logic [6:0] MinChannels  = 7'd4;

  // one channel event as kept in the last-event store
  typedef struct packed {
    logic       note_valid;
    logic [6:0] note;
    logic [4:0] instrument;
    logic [3:0] effect;
    logic [7:0] effect_param;
  } event_t;

  localparam int EventW = $bits(event_t);

  // one result item, last field in the lowest bits
  typedef struct packed {
    logic [6:0]  channels_seen;
    logic [7:0]  effect_param;
    logic [3:0]  effect;
    logic [4:0]  instrument;
    logic [6:0]  note;
    logic        note_valid;
    logic [5:0]  channel;
    logic [15:0] row;
  } result_t;

  localparam int ResultW = $bits(result_t);

endpackage

// ===== rtl/itpu_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module itpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/it_pattern_unpacker_core.sv =====
// packed tracker pattern unpacker, top level
// depends on itpu_pkg, itpu_ram and assert_macros.svh
//
// usage:
//   s_axis carries one packed pattern byte per item in tdata; tuser is the
//   pattern start flag, set on the first byte of a pattern.
//   m_axis carries one decoded channel event per completed entry of a channel below CHANNELS.
//   the apb port holds pattern_rows (0x0) and pattern_bytes (0x4); write
//   them only while the block is idle.
// timing:
//   one byte per cycle while the output queue has room. a byte is read into
//   the channel stores at acceptance and registered into the decode stage,
//   where its result goes into a two-entry output queue once that has room;
//   m_axis_tvalid rises once the result of a completed entry is in the queue.
//   the mask and last-event stores are rams with registered reads; a write
//   and a read of the same entry at the same edge are forwarded.
// reset and stall:
//   reset loads the register defaults and marks every store entry empty, so
//   it reads as zero; pattern start marks every entry empty too, no sweep.
//   while m_axis is stalled the queue holds up to two results; once it is
//   full the decode stage holds and s_axis_tready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module it_pattern_unpacker_core
  import itpu_pkg::*;
#(
  parameter int CHANNELS = DefChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] pattern_start
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] row, [21:16] channel, [22] note_valid, [29:23] note,
  // [34:30] instrument, [38:35] effect, [46:39] effect_param,
  // [53:47] channels_seen, [55:54] zero
  output logic [55:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // parse phases
  localparam logic [2:0] PhChan  = 3'd0;
  localparam logic [2:0] PhMask  = 3'd1;
  localparam logic [2:0] PhNote  = 3'd2;
  localparam logic [2:0] PhIns   = 3'd3;
  localparam logic [2:0] PhVol   = 3'd4;
  localparam logic [2:0] PhFx    = 3'd5;
  localparam logic [2:0] PhParam = 3'd6;

  localparam logic [ChanW:0] ChanLimit = (ChanW + 1)'(CHANNELS);

  // first phase selected by the mask from field index start, else channel
  function automatic logic [2:0] next_phase(input logic [3:0] m, input logic [2:0] start);
    logic [2:0] r;
    r = PhChan;
    for (int i = 3; i >= 0; i--) begin
      if (3'(i) >= start && m[i]) begin
        r = PhNote + 3'(i);
      end
    end
    return r;
  endfunction

  // configuration registers
  logic [15:0] pattern_rows_q, pattern_bytes_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_rows_q  <= PatternRowsRst;
      pattern_bytes_q <= PatternBytesRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegPatternRows:  pattern_rows_q  <= pwdata[15:0];
        RegPatternBytes: pattern_bytes_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegPatternRows:  prdata = {16'd0, pattern_rows_q};
      RegPatternBytes: prdata = {16'd0, pattern_bytes_q};
      default:         prdata = 32'd0;
    endcase
  end

  // handshake between acceptance, decode stage and output queue
  logic       s_accept, b_fire;
  logic       b_valid_q;
  logic [7:0] b_byte_q;
  logic       b_start_q;
  logic [1:0] out_cnt_q;
  logic       out_full;

  assign out_full      = (out_cnt_q == 2'd2);
  assign b_fire        = b_valid_q && !out_full;
  assign s_axis_tready = !b_valid_q || b_fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // store read address from the incoming byte as if it were a channel byte
  logic [ChanW-1:0] rd_addr;
  assign rd_addr = s_axis_tdata[ChanW-1:0] - ChanW'(1);

  // decode stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      b_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      b_byte_q  <= s_axis_tdata;
      b_start_q <= s_axis_tuser;
    end
  end

  // parse state
  logic [2:0]       phase_q, phase_d;
  logic [15:0]      row_q, row_d;
  logic [15:0]      bcnt_q, bcnt_d;
  logic [ChanW-1:0] cur_ch_q, cur_ch_d;
  logic [MaskW-1:0] mask_q, mask_d;
  event_t           ev_q;
  logic [7:0]       hold_q, hold_d;
  logic [ChanW:0]   maxch_q, maxch_d;

  // stores
  logic             mask_we, ev_we;
  logic [ChanW-1:0] ev_waddr;
  logic [MaskW-1:0] mask_rdata;
  event_t           ev_rdata, ev_d;

  itpu_ram #(
    .WIDTH (MaskW),
    .DEPTH (StoreDepth)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (b_fire && mask_we),
    .waddr_i (cur_ch_q),
    .wdata_i (b_byte_q),
    .re_i    (s_accept),
    .raddr_i (rd_addr),
    .rdata_o (mask_rdata)
  );

  itpu_ram #(
    .WIDTH (EventW),
    .DEPTH (StoreDepth)
  ) u_event_ram (
    .clk_i   (clk_i),
    .we_i    (b_fire && ev_we),
    .waddr_i (ev_waddr),
    .wdata_i (ev_d),
    .re_i    (s_accept),
    .raddr_i (rd_addr),
    .rdata_o (ev_rdata)
  );

  // forwarding of a write that lands at the edge of the read
  logic             fwd_m_hit_q, fwd_e_hit_q;
  logic [MaskW-1:0] fwd_m_data_q;
  event_t           fwd_e_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_m_hit_q <= 1'b0;
      fwd_e_hit_q <= 1'b0;
    end else if (s_accept) begin
      fwd_m_hit_q <= b_fire && mask_we && (cur_ch_q == rd_addr);
      fwd_e_hit_q <= b_fire && ev_we && (ev_waddr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      fwd_m_data_q <= b_byte_q;
      fwd_e_data_q <= ev_d;
    end
  end

  // entry valid flags, an empty entry reads as zero
  logic [StoreDepth-1:0] mask_vld_q, mask_vld_d;
  logic [StoreDepth-1:0] ev_vld_q, ev_vld_d;

  // decode of the byte in the stage
  logic [ChanW-1:0] b_ch;
  logic [MaskW-1:0] mask_rd;
  event_t           ev_rd;
  logic [15:0]      row_c, bcnt_c;
  logic [2:0]       phase_c;
  logic             used_up;
  logic             emit;
  logic [3:0]       adv_mask;
  logic [2:0]       adv_start;
  logic             adv;

  assign b_ch = b_byte_q[ChanW-1:0] - ChanW'(1);

  always_comb begin
    // store reads after forwarding and clearing
    mask_rd = '0;
    ev_rd   = '0;
    if (!b_start_q && mask_vld_q[b_ch]) begin
      mask_rd = fwd_m_hit_q ? fwd_m_data_q : mask_rdata;
    end
    if (!b_start_q && ev_vld_q[b_ch]) begin
      ev_rd = fwd_e_hit_q ? fwd_e_data_q : ev_rdata;
    end

    // pattern start clears counters before the byte is parsed
    row_c   = b_start_q ? 16'd0 : row_q;
    bcnt_c  = b_start_q ? 16'd0 : bcnt_q;
    phase_c = b_start_q ? PhChan : phase_q;
    used_up = (bcnt_c >= pattern_bytes_q) || (row_c >= pattern_rows_q);

    row_d     = row_c;
    bcnt_d    = bcnt_c + ((bcnt_c != 16'hFFFF) ? 16'd1 : 16'd0);
    phase_d   = phase_c;
    cur_ch_d  = cur_ch_q;
    mask_d    = mask_q;
    ev_d      = ev_q;
    hold_d    = hold_q;
    maxch_d   = maxch_q;
    mask_we   = 1'b0;
    adv       = 1'b0;
    adv_mask  = mask_q[3:0];
    adv_start = 3'd0;

    unique case (phase_c)
      PhChan: begin
        if (used_up) begin
          phase_d = PhChan;
        end else if (b_byte_q == 8'd0) begin
          row_d = row_c + ((row_c != 16'hFFFF) ? 16'd1 : 16'd0);
        end else begin
          cur_ch_d = b_ch;
          if ({1'b0, b_ch} + (ChanW + 1)'(1) > maxch_q) begin
            maxch_d = {1'b0, b_ch} + (ChanW + 1)'(1);
          end
          ev_d = ev_rd;
          if (b_byte_q[7]) begin
            phase_d = PhMask;
          end else begin
            mask_d   = mask_rd;
            adv      = 1'b1;
            adv_mask = mask_rd[3:0];
          end
        end
      end
      PhMask: begin
        mask_d   = b_byte_q;
        mask_we  = 1'b1;
        adv      = 1'b1;
        adv_mask = b_byte_q[3:0];
      end
      PhNote: begin
        if (b_byte_q < NoteLimit) begin
          ev_d.note_valid = 1'b1;
          ev_d.note       = b_byte_q[6:0];
        end else begin
          ev_d.note_valid = 1'b0;
          ev_d.note       = 7'd0;
        end
        adv       = 1'b1;
        adv_start = 3'd1;
      end
      PhIns: begin
        ev_d.instrument = (b_byte_q > InstrMax) ? InstrMax[4:0] : b_byte_q[4:0];
        adv             = 1'b1;
        adv_start       = 3'd2;
      end
      PhVol: begin
        if (b_byte_q <= VolLimit) begin
          ev_d.effect       = FxSetVolume;
          ev_d.effect_param = b_byte_q;
        end
        adv       = 1'b1;
        adv_start = 3'd3;
      end
      PhFx: begin
        hold_d  = b_byte_q;
        phase_d = PhParam;
      end
      PhParam: begin
        if (hold_q == FxSpeedA || hold_q == FxSpeedB) begin
          ev_d.effect       = FxSetSpeed;
          ev_d.effect_param = b_byte_q;
        end
        adv       = 1'b1;
        adv_start = 3'd4;
      end
      default: begin
        phase_d = PhChan;
      end
    endcase

    // move to the next selected field, finish the entry when none is left
    ev_we = 1'b0;
    emit  = 1'b0;
    if (adv) begin
      phase_d = next_phase(adv_mask, adv_start);
      if (phase_d == PhChan) begin
        ev_we = 1'b1;
        emit  = ({1'b0, cur_ch_d} < ChanLimit);
      end
    end
    ev_waddr = cur_ch_d;

    // valid flags after this byte
    mask_vld_d = b_start_q ? '0 : mask_vld_q;
    ev_vld_d   = b_start_q ? '0 : ev_vld_q;
    if (mask_we) begin
      mask_vld_d[cur_ch_q] = 1'b1;
    end
    if (ev_we) begin
      ev_vld_d[ev_waddr] = 1'b1;
    end
  end

  // parse state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhChan;
      row_q      <= 16'd0;
      bcnt_q     <= 16'd0;
      cur_ch_q   <= '0;
      mask_q     <= '0;
      ev_q       <= '0;
      hold_q     <= 8'd0;
      maxch_q    <= MinChannels;
      mask_vld_q <= '0;
      ev_vld_q   <= '0;
    end else if (b_fire) begin
      phase_q    <= phase_d;
      row_q      <= row_d;
      bcnt_q     <= bcnt_d;
      cur_ch_q   <= cur_ch_d;
      mask_q     <= mask_d;
      ev_q       <= ev_d;
      hold_q     <= hold_d;
      maxch_q    <= maxch_d;
      mask_vld_q <= mask_vld_d;
      ev_vld_q   <= ev_vld_d;
    end
  end

  // result assembly
  result_t res;

  always_comb begin
    res.row           = row_c;
    res.channel       = cur_ch_d;
    res.note_valid    = ev_d.note_valid;
    res.note          = ev_d.note;
    res.instrument    = ev_d.instrument;
    res.effect        = ev_d.effect;
    res.effect_param  = ev_d.effect_param;
    res.channels_seen = maxch_d;
  end

  // two-entry output queue
  result_t out_mem_q [2];
  logic    out_wr_ptr_q, out_rd_ptr_q;
  logic    out_push, out_pop;

  assign out_push = b_fire && emit;
  assign out_pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q    <= 2'd0;
      out_wr_ptr_q <= 1'b0;
      out_rd_ptr_q <= 1'b0;
    end else begin
      if (out_push) begin
        out_wr_ptr_q <= !out_wr_ptr_q;
      end
      if (out_pop) begin
        out_rd_ptr_q <= !out_rd_ptr_q;
      end
      out_cnt_q <= out_cnt_q + (out_push ? 2'd1 : 2'd0) - (out_pop ? 2'd1 : 2'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_mem_q[out_wr_ptr_q] <= res;
    end
  end

  assign m_axis_tvalid = (out_cnt_q != 2'd0);
  assign m_axis_tdata  = {(56 - ResultW)'(0), out_mem_q[out_rd_ptr_q]};

  // checks
  `ASSERT_NEVER(a_queue_bound, out_cnt_q == 2'd3, "output queue count beyond depth")
  `ASSERT_NEVER(a_push_when_full, out_push && out_full, "result pushed into full queue")
  `ASSERT_CLK(a_fx_then_param, (b_fire && !b_start_q && phase_q == PhFx) |=> (phase_q == PhParam), "effect code not followed by parameter phase")
  `ASSERT_CLK(a_fwd_needs_vld, (b_valid_q && !b_start_q && fwd_e_hit_q) |-> ev_vld_q[b_ch], "forwarded event entry not marked valid")

endmodule
